>>> rtl/ulct_pkg.sv
package ulct_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int JOB_BYTES   = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFORM_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURKISH_RULE   = 2'd1;

    // transform modes
    localparam logic [1:0] MODE_NONE       = 2'd0;
    localparam logic [1:0] MODE_UPPER      = 2'd1;
    localparam logic [1:0] MODE_LOWER      = 2'd2;
    localparam logic [1:0] MODE_CAPITALIZE = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } result_t;

    // one queued job: the bytes one input word expands to
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [1:0]                count;   // 1..3
        logic                      last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

endpackage

>>> rtl/ulct_front.sv
module ulct_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ulct_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ulct_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              text_valid,
    output logic                              text_ready,
    input  ulct_pkg::text_t                   text,
    input  logic                              queue_full,
    output logic                              push,
    output ulct_pkg::job_t                    push_job
);

    localparam logic [10:0] CP_CAP_I_DOT   = 11'h130;
    localparam logic [10:0] CP_SMALL_I_DOTLESS = 11'h131;
    localparam logic [10:0] CP_DIVIDE      = 11'h0F7;
    localparam logic [10:0] CP_TIMES       = 11'h0D7;
    localparam logic [10:0] CP_PAIR_B_LO   = 11'h14A;
    localparam logic [10:0] CP_PAIR_B_HI   = 11'h177;
    localparam logic [10:0] CP_UP_C_LO     = 11'h13A;
    localparam logic [10:0] CP_UP_C_HI     = 11'h148;
    localparam logic [10:0] CP_LO_C_LO     = 11'h139;
    localparam logic [10:0] CP_LO_C_HI     = 11'h147;
    localparam logic [10:0] CP_UP_D_LO     = 11'h17A;
    localparam logic [10:0] CP_LO_D_LO     = 11'h179;

    function automatic logic [10:0] to_upper(input logic [10:0] cp, input logic turk);
        logic [10:0] r;
        r = cp;
        if (cp < 11'h080) begin
            if (turk && cp == 11'h069)
                r = CP_CAP_I_DOT;
            else if (cp >= 11'h061 && cp <= 11'h07A)
                r = cp - 11'h020;
        end else if (cp >= 11'h0E0 && cp <= 11'h0FE && cp != CP_DIVIDE) begin
            r = cp - 11'h020;
        end else if (cp == CP_SMALL_I_DOTLESS) begin
            r = 11'h049;
        end else if ((cp >= 11'h100 && cp <= 11'h137) ||
                     (cp >= CP_PAIR_B_LO && cp <= CP_PAIR_B_HI)) begin
            if (cp[0])
                r = cp - 11'd1;
        end else if (cp >= CP_UP_C_LO && cp <= CP_UP_C_HI) begin
            if (!cp[0])
                r = cp - 11'd1;
        end else if (cp >= CP_UP_D_LO && cp <= 11'h17E) begin
            if (!cp[0])
                r = cp - 11'd1;
        end
        return r;
    endfunction

    function automatic logic [10:0] to_lower(input logic [10:0] cp, input logic turk);
        logic [10:0] r;
        r = cp;
        if (cp < 11'h080) begin
            if (turk && cp == 11'h049)
                r = CP_SMALL_I_DOTLESS;
            else if (cp >= 11'h041 && cp <= 11'h05A)
                r = cp + 11'h020;
        end else if (cp >= 11'h0C0 && cp <= 11'h0DE && cp != CP_TIMES) begin
            r = cp + 11'h020;
        end else if (cp == CP_CAP_I_DOT) begin
            r = 11'h069;
        end else if ((cp >= 11'h100 && cp <= 11'h137) ||
                     (cp >= CP_PAIR_B_LO && cp <= CP_PAIR_B_HI)) begin
            if (!cp[0])
                r = cp + 11'd1;
        end else if (cp >= CP_LO_C_LO && cp <= CP_LO_C_HI) begin
            if (cp[0])
                r = cp + 11'd1;
        end else if (cp >= CP_LO_D_LO && cp <= 11'h17D) begin
            if (cp[0])
                r = cp + 11'd1;
        end
        return r;
    endfunction

    logic [1:0]  mode_reg;
    logic        turkish_reg;
    logic        lead_pending_reg, lead_pending_next;
    logic [7:0]  lead_byte_reg, lead_byte_next;
    logic        word_start_reg, word_start_next;

    logic        accept;
    logic        is_cont, is_lead;
    logic        prefix, use_cp, raw_b, set_lead, is_space;
    logic [10:0] cp, mapped;
    logic [7:0]  pl0, pl1;
    logic [1:0]  pl_n;
    logic [7:0]  b;

    assign b          = text.text_byte;
    assign text_ready = !queue_full;
    assign accept     = text_valid && text_ready;
    assign is_cont    = (b[7:6] == 2'b10);
    assign is_lead    = (b[7:5] == 3'b110);

    always_comb
    begin
        prefix   = 1'b0;
        use_cp   = 1'b0;
        raw_b    = 1'b0;
        set_lead = 1'b0;
        cp       = {3'b000, b};
        if (mode_reg == ulct_pkg::MODE_NONE) begin
            prefix = lead_pending_reg;
            raw_b  = 1'b1;
        end else if (lead_pending_reg && is_cont) begin
            use_cp = 1'b1;
            cp     = {lead_byte_reg[4:0], b[5:0]};
        end else begin
            prefix = lead_pending_reg;
            if (!b[7])
                use_cp = 1'b1;
            else if (is_lead && !text.text_last)
                set_lead = 1'b1;
            else
                raw_b = 1'b1;
        end
    end

    assign is_space = (cp == 11'h020) || (cp >= 11'h009 && cp <= 11'h00D);

    always_comb
    begin
        case (mode_reg)
            ulct_pkg::MODE_UPPER:      mapped = to_upper(cp, turkish_reg);
            ulct_pkg::MODE_LOWER:      mapped = to_lower(cp, turkish_reg);
            ulct_pkg::MODE_CAPITALIZE: mapped = word_start_reg ? to_upper(cp, turkish_reg) : cp;
            default:                   mapped = cp;
        endcase
    end

    // re-encode the payload part of the job
    always_comb
    begin
        pl0  = b;
        pl1  = 8'h00;
        pl_n = 2'd0;
        if (use_cp) begin
            if (mapped < 11'h080) begin
                pl0  = mapped[7:0];
                pl_n = 2'd1;
            end else begin
                pl0  = {3'b110, mapped[10:6]};
                pl1  = {2'b10, mapped[5:0]};
                pl_n = 2'd2;
            end
        end else if (raw_b) begin
            pl_n = 2'd1;
        end
    end

    always_comb
    begin
        push_job.last = text.text_last;
        if (prefix) begin
            push_job.bytes[0] = lead_byte_reg;
            push_job.bytes[1] = pl0;
            push_job.bytes[2] = pl1;
        end else begin
            push_job.bytes[0] = pl0;
            push_job.bytes[1] = pl1;
            push_job.bytes[2] = 8'h00;
        end
        push_job.count = {1'b0, prefix} + pl_n;
    end

    assign push = accept && (push_job.count != 2'd0);

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        word_start_next   = word_start_reg;
        if (accept) begin
            if (text.text_last) begin
                lead_pending_next = 1'b0;
                lead_byte_next    = 8'h00;
                word_start_next   = 1'b1;
            end else begin
                lead_pending_next = set_lead;
                if (set_lead)
                    lead_byte_next = b;
                if (use_cp && mode_reg == ulct_pkg::MODE_CAPITALIZE)
                    word_start_next = is_space;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= ulct_pkg::MODE_NONE;
            turkish_reg      <= 1'b0;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
            word_start_reg   <= 1'b1;
        end else begin
            if (cfg_we && cfg_index == ulct_pkg::CFG_TRANSFORM_MODE)
                mode_reg <= cfg_data;
            if (cfg_we && cfg_index == ulct_pkg::CFG_TURKISH_RULE)
                turkish_reg <= cfg_data[0];
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
            word_start_reg   <= word_start_next;
        end
    end

endmodule

>>> rtl/ulct_queue.sv
module ulct_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ulct_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output ulct_pkg::head_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ulct_pkg::job_t  mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/ulct_back.sv
module ulct_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  ulct_pkg::head_t   head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output ulct_pkg::result_t result
);

    logic [1:0] idx_reg, idx_next;
    logic       final_byte;

    assign final_byte   = (idx_reg == head.job.count - 2'd1);
    assign result_valid = head.valid;
    assign pop          = head.valid && result_ready && final_byte;

    always_comb
    begin
        case (idx_reg)
            2'd1:    result.out_byte = head.job.bytes[1];
            2'd2:    result.out_byte = head.job.bytes[2];
            default: result.out_byte = head.job.bytes[0];
        endcase
        result.run_last = final_byte;
        result.text_end = final_byte && head.job.last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (head.valid && result_ready)
            idx_next = final_byte ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

>>> rtl/utf8_latin_case_transform.sv
// channel   dir  handshake                   payload
// text      in   text_valid / text_ready     text.text_byte, text.text_last
// result    out  result_valid / result_ready result.out_byte, .run_last, .text_end
// cfg       in   cfg_we                      cfg_index, cfg_data
//
// A word is accepted every cycle while the job queue has room; decode and case
// mapping finish in the cycle of acceptance. The back end sends one byte per cycle
// while result_ready is high, and a word expands to n bytes (n = 0..3).
// Reset clears the queue, the held lead byte and sets word start; config resets to 0.
// An output stall fills the QUEUE_DEPTH-entry queue, then drops text_ready.
module utf8_latin_case_transform
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ulct_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ulct_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              text_valid,
    output logic                              text_ready,
    input  ulct_pkg::text_t                   text,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ulct_pkg::result_t                 result
);

    logic            queue_full;
    logic            push;
    logic            pop;
    ulct_pkg::job_t  push_job;
    ulct_pkg::head_t head;

    ulct_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    ulct_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .head     (head)
    );

    ulct_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> rtl/ulct_checker.sv
module ulct_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              text_valid,
    input logic              text_ready,
    input ulct_pkg::text_t   text,
    input logic              result_valid,
    input logic              result_ready,
    input ulct_pkg::result_t result
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // end of text only on the last byte of a word's run
    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.text_end |-> result.run_last)
        else $error("text_end without run_last");

    // input backpressure only when output work is waiting
    a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> result_valid)
        else $error("text_ready low with empty queue");

    // a last word in an idle block always yields output next cycle
    a_last_makes_output: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text.text_last && !result_valid |=> result_valid)
        else $error("last word produced no output");

endmodule

bind utf8_latin_case_transform ulct_checker u_ulct_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text         (text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> verif/utf8_latin_case_transform_tb.sv
`timescale 1ns / 1ps

module utf8_latin_case_transform_tb;

    localparam logic [ulct_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [ulct_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 3000;
    localparam int ROUND_WORDS   = 22;

    // expected output words, predicted from the accepted text words
    class case_tracker;
        logic [1:0]        mode;
        logic              turkish;
        logic              lead_pending;
        logic [7:0]        lead_byte;
        logic              word_start;
        logic [7:0]        step_bytes[$];
        ulct_pkg::result_t due_words[$];
        int                mismatches;

        function new();
            mode = ulct_pkg::MODE_NONE;
            turkish = 1'b0;
            lead_pending = 1'b0;
            lead_byte = 8'h00;
            word_start = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [ulct_pkg::CFG_INDEX_W-1:0] idx,
                                logic [ulct_pkg::CFG_DATA_W-1:0] data);
            if (idx == ulct_pkg::CFG_TRANSFORM_MODE)
                mode = data[1:0];
            else if (idx == ulct_pkg::CFG_TURKISH_RULE)
                turkish = data[0];
        endfunction

        function void add_byte(logic [7:0] v);
            step_bytes = {step_bytes, v};
        endfunction

        function logic [10:0] upper_cp(logic [10:0] cp);
            if (cp < 11'h080)
            begin
                if (turkish && cp == 11'h069)
                    return 11'h130;
                return (cp >= 11'h061 && cp <= 11'h07A) ? cp - 11'h020 : cp;
            end
            if (cp >= 11'h0E0 && cp <= 11'h0FE && cp != 11'h0F7)
                return cp - 11'h020;
            if (cp == 11'h131)
                return 11'h049;
            if ((cp >= 11'h100 && cp <= 11'h137) || (cp >= 11'h14A && cp <= 11'h177))
                return cp[0] ? cp - 11'h001 : cp;
            if (cp >= 11'h13A && cp <= 11'h148)
                return cp[0] ? cp : cp - 11'h001;
            if (cp >= 11'h17A && cp <= 11'h17E)
                return cp[0] ? cp : cp - 11'h001;
            return cp;
        endfunction

        function logic [10:0] lower_cp(logic [10:0] cp);
            if (cp < 11'h080)
            begin
                if (turkish && cp == 11'h049)
                    return 11'h131;
                return (cp >= 11'h041 && cp <= 11'h05A) ? cp + 11'h020 : cp;
            end
            if (cp >= 11'h0C0 && cp <= 11'h0DE && cp != 11'h0D7)
                return cp + 11'h020;
            if (cp == 11'h130)
                return 11'h069;
            if ((cp >= 11'h100 && cp <= 11'h137) || (cp >= 11'h14A && cp <= 11'h177))
                return cp[0] ? cp : cp + 11'h001;
            if (cp >= 11'h139 && cp <= 11'h147)
                return cp[0] ? cp + 11'h001 : cp;
            if (cp >= 11'h179 && cp <= 11'h17D)
                return cp[0] ? cp + 11'h001 : cp;
            return cp;
        endfunction

        function void emit_cp(logic [10:0] cp);
            logic [10:0] m;
            m = cp;
            case (mode)
                ulct_pkg::MODE_UPPER: m = upper_cp(cp);
                ulct_pkg::MODE_LOWER: m = lower_cp(cp);
                ulct_pkg::MODE_CAPITALIZE:
                begin
                    if (word_start)
                        m = upper_cp(cp);
                    word_start = (cp == 11'h020 || (cp >= 11'h009 && cp <= 11'h00D));
                end
                default: m = cp;
            endcase
            if (m < 11'h080)
                add_byte(m[7:0]);
            else
            begin
                add_byte({3'b110, m[10:6]});
                add_byte({2'b10, m[5:0]});
            end
        endfunction

        function void note_text_word(ulct_pkg::text_t w);
            logic [7:0]        b;
            logic              last;
            ulct_pkg::result_t r;
            b = w.text_byte;
            last = w.text_last;
            step_bytes.delete();
            if (mode == ulct_pkg::MODE_NONE)
            begin
                if (lead_pending)
                    add_byte(lead_byte);
                lead_pending = 1'b0;
                add_byte(b);
            end
            else if (lead_pending && b[7:6] == 2'b10)
            begin
                lead_pending = 1'b0;
                emit_cp({lead_byte[4:0], b[5:0]});
            end
            else
            begin
                // broken pair: held lead goes out raw ahead of the new byte
                if (lead_pending)
                begin
                    add_byte(lead_byte);
                    lead_pending = 1'b0;
                end
                if (b < 8'h80)
                    emit_cp({3'b000, b});
                else if (b[7:5] == 3'b110 && !last)
                begin
                    lead_pending = 1'b1;
                    lead_byte = b;
                end
                else
                    add_byte(b);
            end
            foreach (step_bytes[i])
            begin
                r.out_byte = step_bytes[i];
                r.run_last = (i == step_bytes.size() - 1);
                r.text_end = (i == step_bytes.size() - 1) && last;
                due_words = {due_words, r};
            end
            if (last)
            begin
                lead_pending = 1'b0;
                lead_byte = 8'h00;
                word_start = 1'b1;
            end
        endfunction

        function void check_out_word(ulct_pkg::result_t got);
            ulct_pkg::result_t want;
            if (due_words.size() == 0)
            begin
                $error("out word with none due: out_byte %h", got.out_byte);
                mismatches++;
                return;
            end
            want = due_words.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte expected %h actual %h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last expected %b actual %b", want.run_last, got.run_last);
                mismatches++;
            end
            if (got.text_end !== want.text_end)
            begin
                $error("text_end expected %b actual %b", want.text_end, got.text_end);
                mismatches++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [ulct_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [ulct_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              text_valid;
    logic                              text_ready;
    ulct_pkg::text_t                   text;
    logic                              result_valid;
    logic                              result_ready;
    ulct_pkg::result_t                 result;

    case_tracker tracker;
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int quiet_cycles = 0;

    utf8_latin_case_transform DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text         (text),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && text_ready)
                tracker.note_text_word(text);
            if (result_valid && result_ready)
                tracker.check_out_word(result);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && text_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("utf8_latin_case_transform: mismatch");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text <= '{text_byte: b, text_last: last};
        do
            @(posedge clk);
        while (!text_ready);
        words_sent++;
    endtask

    // block idle: all due words out, then a margin for a held lead
    task automatic settle();
        text_valid <= 1'b0;
        // let the monitor take the word accepted at this edge first
        @(posedge clk);
        while (tracker.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic turk, input bit poke);
        logic [ulct_pkg::CFG_INDEX_W-1:0] spare_idx;
        logic [ulct_pkg::CFG_DATA_W-1:0]  spare_data;
        cfg_we <= 1'b1;
        cfg_index <= ulct_pkg::CFG_TRANSFORM_MODE;
        cfg_data <= mode;
        @(posedge clk);
        tracker.write_reg(ulct_pkg::CFG_TRANSFORM_MODE, mode);
        cfg_index <= ulct_pkg::CFG_TURKISH_RULE;
        cfg_data <= {1'b0, turk};
        @(posedge clk);
        tracker.write_reg(ulct_pkg::CFG_TURKISH_RULE, {1'b0, turk});
        if (poke)
        begin
            // unmapped index must leave both registers alone
            spare_idx = $urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3;
            spare_data = 2'($urandom);
            cfg_index <= spare_idx;
            cfg_data <= spare_data;
            @(posedge clk);
            tracker.write_reg(spare_idx, spare_data);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed text, some raw noise; an early last now and then
    task automatic send_random_run(input int n);
        logic [7:0] run_bytes[$];
        logic [7:0] c;
        int k;
        int j;
        while (run_bytes.size() < n)
        begin
            k = $urandom_range(99);
            if (k < 40)
            begin
                j = $urandom_range(99);
                if (j < 20)
                    c = $urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9));
                else if (j < 35)
                    c = $urandom_range(1) ? 8'h69 : 8'h49;
                else if (j < 85)
                    c = 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61);
                else
                    c = 8'($urandom_range(127));
                run_bytes = {run_bytes, c};
            end
            else if (k < 85)
            begin
                c = 8'hC2 + 8'($urandom_range(3));
                run_bytes = {run_bytes, c};
                c = {2'b10, 6'($urandom)};
                run_bytes = {run_bytes, c};
            end
            else if (k < 92)
            begin
                c = {3'b110, 5'($urandom)};
                run_bytes = {run_bytes, c};
                c = {2'b10, 6'($urandom)};
                run_bytes = {run_bytes, c};
            end
            else
            begin
                c = 8'($urandom);
                run_bytes = {run_bytes, c};
            end
        end
        foreach (run_bytes[i])
            send_word(run_bytes[i],
                      (i == run_bytes.size() - 1) ? 1'b1 : ($urandom_range(19) == 0));
    endtask

    initial
    begin
        int send_pcts[4];
        int recv_pcts[4];
        int target;
        send_pcts = '{0, 79, 0, 8};
        recv_pcts = '{0, 0, 79, 8};
        tracker = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        text_valid = 1'b0;
        text = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        words_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_config(ulct_pkg::MODE_UPPER, 1'b0, 1'b1);
        send_word(8'h61, 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'hA9, 1'b0);
        // overlong NUL
        send_word(8'hC0, 1'b0);
        send_word(8'h80, 1'b0);
        // lead after lead, then a continuation
        send_word(8'hC5, 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hDF, 1'b1);
        settle();

        set_config(ulct_pkg::MODE_UPPER, 1'b1, 1'b1);
        send_word(8'h69, 1'b0);
        send_word(8'hC4, 1'b0);
        send_word(8'hB1, 1'b1);
        settle();

        set_config(ulct_pkg::MODE_LOWER, 1'b1, 1'b0);
        send_word(8'h49, 1'b0);
        send_word(8'hC4, 1'b0);
        send_word(8'hB0, 1'b0);
        send_word(8'hC5, 1'b0);
        send_word(8'hB9, 1'b1);
        settle();

        set_config(ulct_pkg::MODE_CAPITALIZE, 1'b0, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h20, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'hC3, 1'b0);
        settle();

        // mode switch with a lead still held: it is flushed raw
        set_config(ulct_pkg::MODE_NONE, 1'b0, 1'b0);
        send_word(8'h00, 1'b1);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            for (int r = 0; r < 3; r++)
            begin
                set_config(2'((p * 3 + r) % 4), 1'($urandom_range(1)), $urandom_range(3) == 0);
                target = words_sent + ROUND_WORDS;
                while (words_sent < target)
                    send_random_run($urandom_range(1, 12));
                settle();
            end
        end

        if (tracker.mismatches == 0 && tracker.due_words.size() == 0)
            $display("utf8_latin_case_transform: match");
        else
            $display("utf8_latin_case_transform: mismatch");
        $finish;
    end

endmodule
